/* rtl/chacha20_keystream_xor_unit_macros.svh */
// assertion macros used by the checker file
`ifndef CHACHA20_KEYSTREAM_XOR_UNIT_MACROS_SVH
`define CHACHA20_KEYSTREAM_XOR_UNIT_MACROS_SVH

// antecedent in one cycle implies consequent in the next
`define CX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("keystream unit check failed");

// antecedent implies consequent in the same cycle
`define CX_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("keystream unit check failed");

`endif

/* rtl/cx20_pkg.sv */
// ----------------------------------------------------------------------------
// cx20_pkg
// shared codes and constants of the chacha20 keystream unit
// ----------------------------------------------------------------------------
`default_nettype none

package cx20_pkg;

  // item command codes
  typedef enum logic [1:0] {
    CMD_XOR     = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // configuration register indexes
  localparam logic [2:0] REG_KEY0     = 3'd0;
  localparam logic [2:0] REG_KEY1     = 3'd1;
  localparam logic [2:0] REG_KEY2     = 3'd2;
  localparam logic [2:0] REG_KEY3     = 3'd3;
  localparam logic [2:0] REG_NONCE_LO = 3'd4;
  localparam logic [2:0] REG_NONCE_HI = 3'd5;
  localparam logic [2:0] REG_COUNTER  = 3'd6;
  localparam logic [2:0] REG_MODE     = 3'd7;

  typedef logic [3:0][31:0] const_words_t;

  // "expand 32-byte k" and "expand 16-byte k"
  localparam const_words_t SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
  localparam const_words_t TAU   = {32'h6b206574, 32'h79622d36, 32'h3120646e, 32'h61707865};

endpackage

`default_nettype wire

/* rtl/chacha20_keystream_xor_unit.sv */
// ----------------------------------------------------------------------------
// chacha20_keystream_xor_unit
// chacha20 stream cipher, one byte per item
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item: tuser[1:0] command, tdata[7:0] data byte.
//   m_axis returns one result byte for each xor or extract item.
//   restart (and the unused code) give no result; restart reloads the
//   state from the config registers, which are written over the cfg channel
//   (always ready) and take effect at the next restart.
//   one item is worked at a time. a byte from the stored block is read from the
//   keystream memory into a read register, then into the output register;
//   when the block is used up, the next block first runs its rounds (four
//   quarter-round lanes, one add-xor-rotate step per cycle), then is fed
//   forward into the memory, one word per cycle, before the byte is read.
//   after reset the state holds the zero key with the 256-bit constants and
//   the block buffer is empty. a result stalled on m_axis stays in the
//   output register; the next item is taken once that register is free or
//   being emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_keystream_xor_unit #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic [1:0]  s_axis_tuser,   // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int RW     = (ROUNDS > 2) ? $clog2(ROUNDS) : 1;
  localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FEED  = 4'b0100,
    ST_READ  = 4'b1000
  } fsm_e;

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // word index of lane, row; diagonal rounds shift the column by the row
  function automatic logic [3:0] qidx(logic diag, logic [1:0] lane, logic [1:0] row);
    logic [1:0] col;
    col = diag ? 2'(lane + row) : lane;
    return {row, col};
  endfunction

  // config registers
  logic [63:0] key_q [4];
  logic [63:0] nonce_lo_q;
  logic [31:0] nonce_hi_q;
  logic [63:0] ctr_q;
  logic [1:0]  mode_q;

  // cipher state, working copy, control
  logic [31:0] st_q [16];
  logic [31:0] x_q  [16];
  logic [31:0] x_d  [16];
  logic        long_q;
  logic [6:0]  pos_q, pos_d;
  logic [RW-1:0] rnd_q, rnd_d;
  logic [1:0]  step_q, step_d;
  logic [3:0]  ff_q, ff_d;
  fsm_e        fsm_q, fsm_d;
  logic [1:0]  cmd_q;
  logic [7:0]  data_q;
  logic [1:0]  lane_q;
  logic [7:0]  out_q;
  logic        out_valid_q, out_valid_d;

  // keystream memory, one word per entry
  logic [31:0] ks_mem [16];
  logic [31:0] rdata_q;

  logic        in_acc, is_byte, is_restart, need_gen;
  logic        rd_en, wr_en, load_st, bump_ctr, start_gen;
  logic [3:0]  rd_addr;
  logic [31:0] wr_data;
  logic [7:0]  ks_byte;
  logic [3:0]  ia [4], ib [4], ic [4], id [4];
  logic [31:0] tsum [4];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (fsm_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign is_restart = (s_axis_tuser == cx20_pkg::CMD_RESTART);
  assign is_byte    = (s_axis_tuser == cx20_pkg::CMD_XOR) ||
                      (s_axis_tuser == cx20_pkg::CMD_EXTRACT);
  assign need_gen   = pos_q[6];
  assign load_st    = in_acc && is_restart;
  assign start_gen  = in_acc && is_byte && need_gen;
  assign wr_en      = (fsm_q == ST_FEED);
  assign wr_data    = x_q[ff_q] + st_q[ff_q];
  assign bump_ctr   = (fsm_q == ST_FEED) && (ff_q == 4'd15);
  assign rd_en      = (in_acc && is_byte && !need_gen) || bump_ctr;
  assign rd_addr    = (fsm_q == ST_FEED) ? 4'd0 : pos_q[5:2];
  assign ks_byte    = rdata_q[8*lane_q +: 8];

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      nonce_lo_q <= '0;
      nonce_hi_q <= '0;
      ctr_q      <= '0;
      mode_q     <= 2'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cx20_pkg::REG_KEY0:     key_q[0]   <= cfg_data_i;
        cx20_pkg::REG_KEY1:     key_q[1]   <= cfg_data_i;
        cx20_pkg::REG_KEY2:     key_q[2]   <= cfg_data_i;
        cx20_pkg::REG_KEY3:     key_q[3]   <= cfg_data_i;
        cx20_pkg::REG_NONCE_LO: nonce_lo_q <= cfg_data_i;
        cx20_pkg::REG_NONCE_HI: nonce_hi_q <= cfg_data_i[31:0];
        cx20_pkg::REG_COUNTER:  ctr_q      <= cfg_data_i;
        cx20_pkg::REG_MODE:     mode_q     <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // cipher state: load on restart, counter step after each block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) st_q[i] <= cx20_pkg::SIGMA[i];
      for (int i = 4; i < 16; i++) st_q[i] <= '0;
      long_q <= 1'b0;
    end else if (load_st) begin
      for (int i = 0; i < 4; i++) begin
        st_q[i] <= mode_q[0] ? cx20_pkg::SIGMA[i] : cx20_pkg::TAU[i];
      end
      st_q[4]  <= key_q[0][31:0];
      st_q[5]  <= key_q[0][63:32];
      st_q[6]  <= key_q[1][31:0];
      st_q[7]  <= key_q[1][63:32];
      st_q[8]  <= mode_q[0] ? key_q[2][31:0]  : key_q[0][31:0];
      st_q[9]  <= mode_q[0] ? key_q[2][63:32] : key_q[0][63:32];
      st_q[10] <= mode_q[0] ? key_q[3][31:0]  : key_q[1][31:0];
      st_q[11] <= mode_q[0] ? key_q[3][63:32] : key_q[1][63:32];
      st_q[12] <= ctr_q[31:0];
      st_q[13] <= mode_q[1] ? ctr_q[63:32]      : nonce_lo_q[31:0];
      st_q[14] <= mode_q[1] ? nonce_lo_q[31:0]  : nonce_lo_q[63:32];
      st_q[15] <= mode_q[1] ? nonce_lo_q[63:32] : nonce_hi_q;
      long_q   <= mode_q[1];
    end else if (bump_ctr) begin
      st_q[12] <= st_q[12] + 32'd1;
      if (long_q && (st_q[12] == 32'hffff_ffff)) begin
        st_q[13] <= st_q[13] + 32'd1;
      end
    end
  end

  // quarter-round lanes, one add-xor-rotate step per cycle
  always_comb begin
    x_d = x_q;
    for (int l = 0; l < 4; l++) begin
      ia[l]   = qidx(rnd_q[0], 2'(l), 2'd0);
      ib[l]   = qidx(rnd_q[0], 2'(l), 2'd1);
      ic[l]   = qidx(rnd_q[0], 2'(l), 2'd2);
      id[l]   = qidx(rnd_q[0], 2'(l), 2'd3);
      tsum[l] = step_q[0] ? (x_q[ic[l]] + x_q[id[l]]) : (x_q[ia[l]] + x_q[ib[l]]);
    end
    if (start_gen) begin
      x_d = st_q;
    end else if (fsm_q == ST_ROUND) begin
      for (int l = 0; l < 4; l++) begin
        unique case (step_q)
          2'd0: begin
            x_d[ia[l]] = tsum[l];
            x_d[id[l]] = rotl(x_q[id[l]] ^ tsum[l], 16);
          end
          2'd1: begin
            x_d[ic[l]] = tsum[l];
            x_d[ib[l]] = rotl(x_q[ib[l]] ^ tsum[l], 12);
          end
          2'd2: begin
            x_d[ia[l]] = tsum[l];
            x_d[id[l]] = rotl(x_q[id[l]] ^ tsum[l], 8);
          end
          default: begin
            x_d[ic[l]] = tsum[l];
            x_d[ib[l]] = rotl(x_q[ib[l]] ^ tsum[l], 7);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  // sequencer
  always_comb begin
    fsm_d       = fsm_q;
    pos_d       = pos_q;
    rnd_d       = rnd_q;
    step_d      = step_q;
    ff_d        = ff_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (fsm_q)
      ST_IDLE: begin
        if (load_st) begin
          pos_d = 7'd64;
        end else if (start_gen) begin
          rnd_d  = '0;
          step_d = 2'd0;
          fsm_d  = ST_ROUND;
        end else if (rd_en) begin
          pos_d = pos_q + 7'd1;
          fsm_d = ST_READ;
        end
      end
      ST_ROUND: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          rnd_d = rnd_q + RW'(1);
          if (rnd_q == LAST_ROUND) begin
            ff_d  = 4'd0;
            fsm_d = ST_FEED;
          end
        end
      end
      ST_FEED: begin
        ff_d = ff_q + 4'd1;
        if (bump_ctr) begin
          pos_d = 7'd1;
          fsm_d = ST_READ;
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        fsm_d       = ST_IDLE;
      end
      default: fsm_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      pos_q       <= 7'd64;
      rnd_q       <= '0;
      step_q      <= 2'd0;
      ff_q        <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      pos_q       <= pos_d;
      rnd_q       <= rnd_d;
      step_q      <= step_d;
      ff_q        <= ff_d;
      out_valid_q <= out_valid_d;
    end
  end

  // held item and byte lane
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= s_axis_tuser;
      data_q <= s_axis_tdata;
    end
    if (rd_en) begin
      lane_q <= (fsm_q == ST_FEED) ? 2'd0 : pos_q[1:0];
    end
    if (fsm_q == ST_READ) begin
      out_q <= (cmd_q == cx20_pkg::CMD_XOR) ? (ks_byte ^ data_q) : ks_byte;
    end
  end

  // keystream memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ks_mem[ff_q] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= ks_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/cx20_checker.sv */
// ----------------------------------------------------------------------------
// cx20_checker
// port-level checks of the chacha20 keystream unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "chacha20_keystream_xor_unit_macros.svh"

module cx20_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,   // command
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata    // out_byte
);

  logic in_acc, byte_cmd, restart_cmd;

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign byte_cmd    = (s_axis_tuser == cx20_pkg::CMD_XOR) ||
                       (s_axis_tuser == cx20_pkg::CMD_EXTRACT);
  assign restart_cmd = (s_axis_tuser == cx20_pkg::CMD_RESTART);

  // a stalled result holds
  `CX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // a restart item never leaves a result behind it
  `CX_ASSERT_NEXT(a_restart_quiet, clk_i, rst_ni, in_acc && restart_cmd, !m_axis_tvalid)
  // a byte item drops the input ready right after it is accepted
  `CX_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_acc && byte_cmd, !s_axis_tready)
  // input is never taken while a stalled result blocks the output register
  `CX_ASSERT_SAME(a_no_overrun, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

bind chacha20_keystream_xor_unit cx20_checker u_cx20_checker (.*);

`default_nettype wire
